// File: src/lbdf_pkg.sv
package lbdf_pkg;

    localparam int BARS_DEF = 8;

    localparam int TIME_W  = 32;
    localparam int SLIDE_W = 3;
    localparam int LED_W   = 3;
    localparam int BRIGHT_W = 8;
    localparam int CFG_W   = 16;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [1:0] REG_SETTLE  = 2'd0;
    localparam logic [1:0] REG_STEP    = 2'd1;
    localparam logic [1:0] REG_RESTART = 2'd2;
    localparam logic [1:0] REG_PREROLL = 2'd3;

    localparam logic [CFG_W-1:0] SETTLE_RST  = 16'd500;
    localparam logic [CFG_W-1:0] STEP_RST    = 16'd125;
    localparam logic [CFG_W-1:0] RESTART_RST = 16'd750;
    localparam logic [CFG_W-1:0] PREROLL_RST = 16'd300;

    localparam int FADE_MS      = 250;
    localparam int FADE_HALF_MS = 125;
    localparam int FADE_SQ      = 62500;
    localparam logic [BRIGHT_W-1:0] FULL_ON = 8'hFF;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ms;
        logic [CFG_W-1:0] step_ms;
        logic [CFG_W-1:0] restart_ms;
        logic [CFG_W-1:0] preroll_ms;
    } cfg_t;

    typedef logic [BRIGHT_W-1:0] fade_lut_t [256];

    function automatic fade_lut_t build_fade_lut();
        fade_lut_t t;
        for (int e = 0; e < 256; e++)
        begin
            if (e < FADE_HALF_MS)
                t[e] = BRIGHT_W'((255 * (FADE_SQ - 2 * e * e)) / FADE_SQ);
            else if (e < FADE_MS)
                t[e] = BRIGHT_W'((510 * (FADE_MS - e) * (FADE_MS - e)) / FADE_SQ);
            else
                t[e] = '0;
        end
        return t;
    endfunction

    localparam fade_lut_t FADE_LUT = build_fade_lut();

endpackage

// File: src/lbdf_tick_if.sv
interface lbdf_tick_if;
    import lbdf_pkg::*;

    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   now_ms;
    logic [SLIDE_W-1:0]  slider_pos;

    modport source (output valid, output now_ms, output slider_pos, input ready);
    modport sink   (input valid, input now_ms, input slider_pos, output ready);
endinterface

// File: src/lbdf_led_if.sv
interface lbdf_led_if;
    import lbdf_pkg::*;

    logic                valid;
    logic                ready;
    logic [LED_W-1:0]    led_index;
    logic [BRIGHT_W-1:0] brightness;
    logic                last;

    modport source (output valid, output led_index, output brightness, output last,
                    input ready);
    modport sink   (input valid, input led_index, input brightness, input last,
                    output ready);
endinterface

// File: src/led_bar_drop_fade_animator_top.sv
// After a tick item is accepted, the engine passes the mode and step states, then
// sweeps the bars through the read stage and the output register. Each tick yields
// BARS results, one per cycle while the sink keeps ready high. A new tick is accepted
// only after the sweep of the fade-start memory through its single read port is done.
// Reset (rst_n, async, active low): registers take defaults, idle mode, all fades off.
module led_bar_drop_fade_animator_top #(
    parameter int BARS = lbdf_pkg::BARS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lbdf_pkg::APB_AW-1:0] paddr,
    input  logic [lbdf_pkg::APB_DW-1:0] pwdata,
    output logic [lbdf_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    lbdf_tick_if.sink                   tick,
    lbdf_led_if.source                  led
);
    import lbdf_pkg::*;

    localparam int IDX_W = $clog2(BARS);

    cfg_t              cfg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [TIME_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] rd_data;

    lbdf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lbdf_start_ram #(.BARS(BARS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lbdf_engine #(.BARS(BARS)) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .tick    (tick),
        .led     (led),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );
endmodule

// File: src/lbdf_cfg_regs.sv
module lbdf_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lbdf_pkg::APB_AW-1:0] paddr,
    input  logic [lbdf_pkg::APB_DW-1:0] pwdata,
    output logic [lbdf_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output lbdf_pkg::cfg_t              cfg
);
    import lbdf_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ms  <= SETTLE_RST;
            cfg_reg.step_ms    <= STEP_RST;
            cfg_reg.restart_ms <= RESTART_RST;
            cfg_reg.preroll_ms <= PREROLL_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_SETTLE:  cfg_reg.settle_ms  <= pwdata[CFG_W-1:0];
                REG_STEP:    cfg_reg.step_ms    <= pwdata[CFG_W-1:0];
                REG_RESTART: cfg_reg.restart_ms <= pwdata[CFG_W-1:0];
                REG_PREROLL: cfg_reg.preroll_ms <= pwdata[CFG_W-1:0];
                default:     cfg_reg.settle_ms  <= cfg_reg.settle_ms;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SETTLE:  prdata = APB_DW'(cfg_reg.settle_ms);
            REG_STEP:    prdata = APB_DW'(cfg_reg.step_ms);
            REG_RESTART: prdata = APB_DW'(cfg_reg.restart_ms);
            REG_PREROLL: prdata = APB_DW'(cfg_reg.preroll_ms);
            default:     prdata = '0;
        endcase
    end
endmodule

// File: src/lbdf_start_ram.sv
module lbdf_start_ram #(
    parameter int BARS = lbdf_pkg::BARS_DEF
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(BARS)-1:0]     wr_addr,
    input  logic [lbdf_pkg::TIME_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(BARS)-1:0]     rd_addr,
    output logic [lbdf_pkg::TIME_W-1:0] rd_data
);
    import lbdf_pkg::*;

    logic [TIME_W-1:0] mem [BARS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule

// File: src/lbdf_engine.sv
module lbdf_engine #(
    parameter int BARS = lbdf_pkg::BARS_DEF,
    localparam int IDX_W = $clog2(BARS),
    localparam int CNT_W = $clog2(BARS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lbdf_pkg::cfg_t              cfg,
    lbdf_tick_if.sink                   tick,
    lbdf_led_if.source                  led,
    output logic                        wr_en,
    output logic [IDX_W-1:0]            wr_addr,
    output logic [lbdf_pkg::TIME_W-1:0] wr_data,
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_addr,
    input  logic [lbdf_pkg::TIME_W-1:0] rd_data
);
    import lbdf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MODE, S_STEP, S_SWEEP} state_t;

    state_t              state_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [SLIDE_W-1:0]  n_reg;
    logic                moving_reg;
    logic [SLIDE_W-1:0]  prev_reg;
    logic [TIME_W-1:0]   change_reg;
    logic [TIME_W-1:0]   step_time_reg;
    logic [SLIDE_W-1:0]  drop_reg;
    logic [BARS-1:0]     live_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                s1_valid_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic                out_valid_reg;
    logic [LED_W-1:0]    out_led_reg;
    logic [BRIGHT_W-1:0] out_bright_reg;
    logic                out_last_reg;

    logic [SLIDE_W-1:0]  n_clamp;
    logic [TIME_W-1:0]   since_change;
    logic [TIME_W-1:0]   since_step;
    logic                step_due;
    logic                restart_due;
    logic                fire;
    logic [SLIDE_W-1:0]  drop_next;
    logic                issue;
    logic                s1_adv;
    logic [TIME_W-1:0]   elapsed;
    logic                expired;
    logic                s1_live;
    logic [BRIGHT_W-1:0] bright;

    assign n_clamp = (32'(tick.slider_pos) > BARS - 1) ? SLIDE_W'(BARS - 1) : tick.slider_pos;

    assign since_change = now_reg - change_reg;
    assign since_step   = now_reg - step_time_reg;
    assign step_due     = !moving_reg && (since_step > TIME_W'(cfg.step_ms));
    assign restart_due  = since_step > TIME_W'(cfg.restart_ms);

    always_comb
    begin
        fire      = 1'b0;
        drop_next = drop_reg;
        if (step_due)
        begin
            priority if (drop_reg != '0)
            begin
                drop_next = drop_reg - 1'b1;
                fire      = 1'b1;
            end
            else if (restart_due)
            begin
                drop_next = n_reg;
                fire      = 1'b1;
            end
            else
            begin
                fire = 1'b0;
            end
        end
    end

    assign wr_en   = (state_reg == S_STEP) && fire;
    assign wr_addr = IDX_W'(drop_next);
    assign wr_data = now_reg;

    assign s1_adv  = s1_valid_reg && (!out_valid_reg || led.ready);
    assign issue   = (state_reg == S_SWEEP) && (cnt_reg < CNT_W'(BARS))
                     && (!s1_valid_reg || s1_adv);
    assign rd_en   = issue;
    assign rd_addr = cnt_reg[IDX_W-1:0];

    assign elapsed = now_reg - rd_data;
    assign expired = elapsed >= TIME_W'(FADE_MS);
    assign s1_live = live_reg[s1_idx_reg];

    always_comb
    begin
        priority if (32'(s1_idx_reg) == 32'(n_reg))
            bright = FULL_ON;
        else if (moving_reg || !s1_live || expired)
            bright = '0;
        else
            bright = FADE_LUT[elapsed[7:0]];
    end

    assign tick.ready     = (state_reg == S_IDLE);
    assign led.valid      = out_valid_reg;
    assign led.led_index  = out_led_reg;
    assign led.brightness = out_bright_reg;
    assign led.last       = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            n_reg          <= '0;
            moving_reg     <= 1'b0;
            prev_reg       <= '0;
            change_reg     <= '0;
            step_time_reg  <= '0;
            drop_reg       <= '0;
            live_reg       <= '0;
            cnt_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s1_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_led_reg    <= '0;
            out_bright_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (tick.valid)
                    begin
                        now_reg   <= tick.now_ms;
                        n_reg     <= n_clamp;
                        state_reg <= S_MODE;
                    end
                end
                S_MODE:
                begin
                    if (n_reg != prev_reg)
                    begin
                        moving_reg <= 1'b1;
                        prev_reg   <= n_reg;
                        change_reg <= now_reg;
                    end
                    else if (moving_reg && (since_change > TIME_W'(cfg.settle_ms)))
                    begin
                        moving_reg    <= 1'b0;
                        drop_reg      <= n_reg;
                        step_time_reg <= now_reg - TIME_W'(cfg.preroll_ms);
                    end
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    drop_reg <= drop_next;
                    if (fire)
                    begin
                        step_time_reg <= now_reg;
                        live_reg[IDX_W'(drop_next)] <= 1'b1;
                    end
                    cnt_reg   <= '0;
                    state_reg <= S_SWEEP;
                end
                S_SWEEP:
                begin
                    if ((cnt_reg == CNT_W'(BARS)) && !s1_valid_reg)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            // drop expired fades as each entry passes
            if (s1_adv && s1_live && expired)
                live_reg[s1_idx_reg] <= 1'b0;

            if (issue)
            begin
                cnt_reg      <= cnt_reg + 1'b1;
                s1_valid_reg <= 1'b1;
                s1_idx_reg   <= cnt_reg[IDX_W-1:0];
            end
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                out_valid_reg  <= 1'b1;
                out_led_reg    <= LED_W'(s1_idx_reg);
                out_bright_reg <= bright;
                out_last_reg   <= (32'(s1_idx_reg) == BARS - 1);
            end
            else if (led.ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_s1_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (state_reg == S_SWEEP))
        else $error("read stage busy outside sweep");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(BARS))
        else $error("sweep count beyond bar length");

    a_write_sets_live: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> live_reg[$past(wr_addr)])
        else $error("new fade not marked live");

    a_no_fade_moving: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) && moving_reg |-> !wr_en)
        else $error("fade started in moving mode");
endmodule
